// File: rtl/core/bae_pkg.sv
// Shared types and constants of the binary arithmetic encoder.
package bae_pkg;

   localparam int PROB_W      = 12;
   localparam int RANGE_W     = 32;
   localparam int BYTE_W      = 8;
   localparam int MAX_BYTES   = 4;
   localparam int CNT_W       = $clog2(MAX_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PROB_W-1:0]  PROB_HALF  = PROB_W'(2048);
   localparam logic [RANGE_W-1:0] LOW_RESET  = '0;
   localparam logic [RANGE_W-1:0] HIGH_RESET = '1;

   // One classified input word as it waits for the back end.
   typedef struct packed {
      logic              flush;
      logic              bit_value;
      logic [PROB_W-1:0] prob;       // already raised, 1..4095
   } entry_type;

   // Head of the queue as the back end sees it.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_head_type;

endpackage

// File: rtl/core/bae_front.sv
// Front end: accepts input words, raises low probabilities, queues them.
module bae_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_bit_value,
   input  logic [11:0]           req_prob_one,
   input  logic                  req_flush,
   output bae_pkg::q_head_type   head,
   input  logic                  pop
);

   bae_pkg::entry_type                entry_ff [bae_pkg::QUEUE_DEPTH];
   logic [bae_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [bae_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [bae_pkg::QCNT_W-1:0]        count_ff, count_in;
   bae_pkg::entry_type                new_entry;
   logic                              wr_en, rd_en;

   assign req_ready = (count_ff != bae_pkg::QCNT_W'(bae_pkg::QUEUE_DEPTH));
   assign wr_en     = req_valid && req_ready;
   assign rd_en     = pop && (count_ff != '0);

   always_comb begin
      new_entry.flush     = req_flush;
      new_entry.bit_value = req_bit_value;
      if (req_prob_one < bae_pkg::PROB_HALF) begin
         new_entry.prob = req_prob_one + bae_pkg::PROB_W'(1);
      end else begin
         new_entry.prob = req_prob_one;
      end
   end

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + bae_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + bae_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + bae_pkg::QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - bae_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entry_ff[rd_ptr_ff];

endmodule

// File: rtl/core/bae_back.sv
// Back end: range split, range update, flush and byte shift-out into the output register.
module bae_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bae_pkg::q_head_type   head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last_of_run
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_UPD  = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [bae_pkg::RANGE_W-1:0]        low_ff, low_in;
   logic [bae_pkg::RANGE_W-1:0]        high_ff, high_in;
   logic [bae_pkg::RANGE_W-1:0]        diff_ff, diff_in;
   logic [bae_pkg::RANGE_W-1:0]        prod_hi_ff, prod_hi_in;
   logic [bae_pkg::PROB_W-1:0]         prod_lo_ff, prod_lo_in;
   logic [bae_pkg::PROB_W-1:0]         prob_ff, prob_in;
   logic                               bit_ff, bit_in;
   logic [bae_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [bae_pkg::BYTE_W-1:0]         byte_ff, byte_in;
   logic                               last_ff, last_in;

   logic                               out_free;
   logic [bae_pkg::RANGE_W-1:0]        mul_hi;
   logic [2*bae_pkg::PROB_W-1:0]       mul_lo;
   logic [bae_pkg::RANGE_W-1:0]        mid;
   logic                               agree, more;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign mul_hi = bae_pkg::RANGE_W'(diff_ff[bae_pkg::RANGE_W-1:bae_pkg::PROB_W])
                   * bae_pkg::RANGE_W'(prob_ff);
   assign mul_lo = (2*bae_pkg::PROB_W)'(diff_ff[bae_pkg::PROB_W-1:0])
                   * (2*bae_pkg::PROB_W)'(prob_ff);
   assign mid    = low_ff + prod_hi_ff + bae_pkg::RANGE_W'(prod_lo_ff);

   assign agree = (low_ff[31:24] == high_ff[31:24]);
   assign more  = (low_ff[23:16] == high_ff[23:16])
                  && (cnt_ff != bae_pkg::CNT_W'(bae_pkg::MAX_BYTES - 1));

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      diff_in      = diff_ff;
      prod_hi_in   = prod_hi_ff;
      prod_lo_in   = prod_lo_ff;
      prob_in      = prob_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      byte_in      = byte_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               if (head.entry.flush) begin
                  // flush: one word of low's top byte, then restart the range
                  if (out_free) begin
                     pop          = 1'b1;
                     rsp_valid_in = 1'b1;
                     byte_in      = low_ff[31:24];
                     last_in      = 1'b1;
                     low_in       = bae_pkg::LOW_RESET;
                     high_in      = bae_pkg::HIGH_RESET;
                  end
               end else begin
                  pop      = 1'b1;
                  diff_in  = high_ff - low_ff;
                  prob_in  = head.entry.prob;
                  bit_in   = head.entry.bit_value;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_hi_in = mul_hi;
            prod_lo_in = mul_lo[2*bae_pkg::PROB_W-1:bae_pkg::PROB_W];
            state_in   = S_UPD;
         end
         S_UPD: begin
            if (bit_ff) begin
               high_in = mid;
            end else begin
               low_in = mid + bae_pkg::RANGE_W'(1);
            end
            cnt_in   = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!agree) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               byte_in      = high_ff[31:24];
               last_in      = !more;
               low_in       = {low_ff[23:0], 8'h00};
               high_in      = {high_ff[23:0], 8'hff};
               cnt_in       = cnt_ff + bae_pkg::CNT_W'(1);
               if (!more) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_ff       <= bae_pkg::LOW_RESET;
         high_ff      <= bae_pkg::HIGH_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff    <= diff_in;
      prod_hi_ff <= prod_hi_in;
      prod_lo_ff <= prod_lo_in;
      prob_ff    <= prob_in;
      bit_ff     <= bit_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// File: rtl/core/binary_arithmetic_encoder_unit.sv
// Binary arithmetic encoder: each input word codes one bit against a 12-bit
// probability of a one and yields zero to four output bytes; a flush word
// yields exactly one byte (low's top byte) and restarts the range. Input words
// land in a two-entry queue, so up to two are taken while the coder is busy.
// A flush is handled in the coder once the output register is free; a coded
// bit passes through range difference, split multiply and range update, then
// shifts out one byte at a time, or finds that no top byte agrees. The coder
// takes the next word only after it is through with the last; the serial byte
// shift-out through the single output register sets its pace, and rsp_ready
// holding a byte back stalls it. Output bytes wait for rsp_ready.
module binary_arithmetic_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_bit_value,
   input  logic [11:0] req_prob_one,
   input  logic        req_flush,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run
);

   bae_pkg::q_head_type head;
   logic                pop;

   bae_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_bit_value (req_bit_value),
      .req_prob_one  (req_prob_one),
      .req_flush     (req_flush),
      .head          (head),
      .pop           (pop)
   );

   bae_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// File: rtl/core/bae_checker.sv
// Port-level checks of the encoder, bound to the top level.
module bae_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   logic [1:0] run_ff, run_in;
   logic       rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   // count words of the current run that were not marked last
   always_comb begin
      run_in = run_ff;
      if (rsp_take) begin
         run_in = rsp_last_of_run ? 2'd0 : run_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_last_of_run))
      else $error("output word changed while stalled");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_last_of_run |-> run_ff != 2'd3)
      else $error("more than four words in one run");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output word right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("input not ready right after reset");

endmodule

bind binary_arithmetic_encoder_unit bae_checker u_bae_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);
